// File: src/lyndon_word_generator_assert.svh
// Assertion macros for the Lyndon word generator.
// All checks run on i_clk and are held off while i_rst_n is low.
`ifndef LYNDON_WORD_GENERATOR_ASSERT_SVH
`define LYNDON_WORD_GENERATOR_ASSERT_SVH

// Same-cycle implication
`define LWG_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lyndon_word_generator: same-cycle check failed");

// Next-cycle implication
`define LWG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lyndon_word_generator: next-cycle check failed");

`endif

// File: src/lwg_pkg.sv
package lwg_pkg;

    // Configuration register layout
    localparam int ALPHA_W    = 5;
    localparam int WLEN_W     = 4;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 1'd1;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 5'd2;
    localparam logic [WLEN_W-1:0]  WLEN_RESET  = 4'd12;

    // Controller to datapath
    typedef struct packed {
        logic load;     // request beat taken: clear found flag
        logic restart;  // with load: begin listing anew
        logic inc;      // start or increment last symbol
        logic ext_sel;  // read port points at len - period
        logic ext;      // copy one symbol periodically
        logic trim;     // drop one trailing maximal symbol
        logic finish;   // iteration over: latch exhaustion
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic exhausted;
        logic got;
        logic ext_done;
        logic trim_done;
        logic len_zero;
    } t_status;

endpackage

// File: src/lyndon_word_generator.sv
// Channel   Handshake                   Payload
// request   i_in_valid / o_in_stall     i_restart
// result    o_out_valid / i_out_stall   o_word_symbols, o_found
// config    i_cfg_we                    i_cfg_index, i_cfg_data
//
// One request at a time. A request runs a load step and an evaluate step, then,
// per iteration, an increment step, an extend step and a trim step, then a
// result state; the extend and trim steps walk the symbol buffer one
// position a cycle through its single read port. Reset is synchronous, active low,
// and restarts the listing. A stalled result holds until taken.
`include "lyndon_word_generator_assert.svh"

module lyndon_word_generator import lwg_pkg::*; #(
    parameter int MAX_LENGTH  = 12,
    parameter int SYMBOL_BITS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_restart,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [MAX_LENGTH*SYMBOL_BITS-1:0] o_word_symbols,
    output logic                              o_found,
    input  logic                              i_cfg_we,
    input  logic [CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [CFG_DATA_W-1:0]             i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    lwg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    lwg_datapath #(
        .MAX_LENGTH  (MAX_LENGTH),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_word_symbols (o_word_symbols)
    );

    assign o_found = w_status.got;

    // No new request while a result is pending
    `LWG_ASSERT_NOW(a_busy_while_result, o_out_valid, o_in_stall)
    // A miss carries an all-zero word
    `LWG_ASSERT_NOW(a_miss_is_zero, o_out_valid && !o_found, o_word_symbols == '0)
    // A taken request keeps the input side busy next cycle
    `LWG_ASSERT_NEXT(a_accept_then_busy, i_in_valid && !o_in_stall, o_in_stall)

endmodule

// File: src/lwg_datapath.sv
module lwg_datapath import lwg_pkg::*; #(
    parameter int MAX_LENGTH  = 12,
    parameter int SYMBOL_BITS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [CFG_DATA_W-1:0]             i_cfg_data,
    input  t_cmd                              i_cmd,
    output t_status                           o_status,
    output logic [MAX_LENGTH*SYMBOL_BITS-1:0] o_word_symbols
);

    localparam int LW  = $clog2(MAX_LENGTH + 1);
    localparam int AW  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int CAP = (SYMBOL_BITS >= 4) ? 16 : (1 << SYMBOL_BITS);

    logic [SYMBOL_BITS-1:0] r_buf [MAX_LENGTH];
    logic [LW-1:0]          r_len;
    logic [LW-1:0]          r_period;
    logic                   r_at_start;
    logic                   r_exhausted;
    logic                   r_got;
    logic [ALPHA_W-1:0]     r_alpha;
    logic [WLEN_W-1:0]      r_wlen;

    logic [ALPHA_W-1:0]     w_alpha;
    logic [SYMBOL_BITS-1:0] w_top;
    logic [4:0]             w_n5;
    logic [LW-1:0]          w_n;
    logic [LW-1:0]          w_rd_full;
    logic [AW-1:0]          w_rd_addr;
    logic [AW-1:0]          w_wr_addr;
    logic [SYMBOL_BITS-1:0] w_rd_data;

    // Saturate alphabet and length into their usable ranges
    always_comb begin
        w_alpha = r_alpha;
        if (w_alpha > ALPHA_W'(CAP)) begin
            w_alpha = ALPHA_W'(CAP);
        end
        if (w_alpha < ALPHA_W'(2)) begin
            w_alpha = ALPHA_W'(2);
        end
        w_top = SYMBOL_BITS'(w_alpha - ALPHA_W'(1));

        w_n5 = {1'b0, r_wlen};
        if (w_n5 > 5'(MAX_LENGTH)) begin
            w_n5 = 5'(MAX_LENGTH);
        end
        if (w_n5 == 5'd0) begin
            w_n5 = 5'd1;
        end
        w_n = LW'(w_n5);
    end

    // Single read port: len - period while extending, else len - 1
    assign w_rd_full = i_cmd.ext_sel ? (r_len - r_period) : (r_len - LW'(1));
    assign w_rd_addr = w_rd_full[AW-1:0];
    assign w_wr_addr = r_len[AW-1:0];

    always_comb begin
        w_rd_data = '0;
        for (int i = 0; i < MAX_LENGTH; i++) begin
            if (w_rd_addr == AW'(i)) begin
                w_rd_data = r_buf[i];
            end
        end
    end

    // Symbol buffer writes
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_LENGTH; i++) begin
            if (i_cmd.inc && r_at_start) begin
                if (i == 0) begin
                    r_buf[i] <= '0;
                end
            end else if (i_cmd.inc && (w_rd_addr == AW'(i))) begin
                r_buf[i] <= w_rd_data + SYMBOL_BITS'(1);
            end else if (i_cmd.ext && (w_wr_addr == AW'(i))) begin
                r_buf[i] <= w_rd_data;
            end
        end
    end

    // Listing control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= ALPHA_RESET;
            r_wlen      <= WLEN_RESET;
            r_len       <= '0;
            r_period    <= '0;
            r_at_start  <= 1'b1;
            r_exhausted <= 1'b0;
            r_got       <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ALPHABET: r_alpha <= i_cfg_data[ALPHA_W-1:0];
                CFG_LENGTH:   r_wlen  <= i_cfg_data[WLEN_W-1:0];
                default:      r_alpha <= r_alpha;
            endcase
            r_len       <= '0;
            r_at_start  <= 1'b1;
            r_exhausted <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_got <= 1'b0;
                if (i_cmd.restart) begin
                    r_len       <= '0;
                    r_at_start  <= 1'b1;
                    r_exhausted <= 1'b0;
                end
            end
            if (i_cmd.inc) begin
                if (r_at_start) begin
                    r_len      <= LW'(1);
                    r_period   <= LW'(1);
                    r_at_start <= 1'b0;
                    r_got      <= (w_n == LW'(1));
                end else begin
                    r_period <= r_len;
                    r_got    <= (r_len == w_n);
                end
            end
            if (i_cmd.ext) begin
                r_len <= r_len + LW'(1);
            end
            if (i_cmd.trim) begin
                r_len <= r_len - LW'(1);
            end
            if (i_cmd.finish && (r_len == '0)) begin
                r_exhausted <= 1'b1;
            end
        end
    end

    // Status back to the controller
    assign o_status.exhausted = r_exhausted;
    assign o_status.got       = r_got;
    assign o_status.ext_done  = !(r_len < w_n);
    assign o_status.trim_done = (r_len == '0) || (w_rd_data != w_top);
    assign o_status.len_zero  = (r_len == '0);

    // Packed word; zero past the word length and when nothing was found
    always_comb begin
        for (int i = 0; i < MAX_LENGTH; i++) begin
            o_word_symbols[i*SYMBOL_BITS +: SYMBOL_BITS] =
                (r_got && (LW'(i) < w_n)) ? r_buf[i] : '0;
        end
    end

endmodule

// File: src/lwg_ctrl.sv
module lwg_ctrl import lwg_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  logic    i_restart,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_INC  = 3'd2;
    localparam logic [2:0] S_EXT  = 3'd3;
    localparam logic [2:0] S_TRIM = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.restart = i_restart;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = i_status.exhausted ? S_OUT : S_INC;
            end
            S_INC: begin
                o_cmd.inc = 1'b1;
                n_state   = S_EXT;
            end
            S_EXT: begin
                o_cmd.ext_sel = 1'b1;
                if (!i_status.ext_done) begin
                    o_cmd.ext = 1'b1;
                end else begin
                    n_state = S_TRIM;
                end
            end
            S_TRIM: begin
                if (!i_status.trim_done) begin
                    o_cmd.trim = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state = (i_status.got || i_status.len_zero) ? S_OUT : S_INC;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: verif/tb.sv
module tb import lwg_pkg::*; ();

    localparam int MAX_LEN = 12;
    localparam int SYM_W   = 4;
    localparam int WORD_W  = MAX_LEN * SYM_W;

    typedef struct {
        logic [WORD_W-1:0] symbols;
        logic              found;
    } t_word_beat;

    // Tracks the listing position, predicts each word and checks what comes back
    class lyndon_listing;
        logic [ALPHA_W-1:0] alpha_reg;
        logic [WLEN_W-1:0]  len_reg;
        logic [SYM_W-1:0]   sym [MAX_LEN];
        int unsigned        cur_len;
        bit                 at_start;
        bit                 exhausted;
        t_word_beat         pending_words[$];
        int unsigned        mismatches;

        function void restart_listing();
            foreach (sym[i]) sym[i] = '0;
            cur_len   = 0;
            at_start  = 1'b1;
            exhausted = 1'b0;
        endfunction

        function void reset_regs();
            alpha_reg = ALPHA_RESET;
            len_reg   = WLEN_RESET;
            restart_listing();
        endfunction

        // Any write to a known register restarts the listing
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ALPHABET: alpha_reg = data[ALPHA_W-1:0];
                CFG_LENGTH:   len_reg   = data[WLEN_W-1:0];
                default:      return;
            endcase
            restart_listing();
        endfunction

        function int unsigned pending();
            return pending_words.size();
        endfunction

        // Run increment / extend / trim until a full-length word shows up or the listing runs dry
        function void take_request(bit restart_req);
            int unsigned      span;
            int unsigned      n;
            int unsigned      period;
            logic [SYM_W-1:0] top;
            t_word_beat       beat;

            span = (alpha_reg > 16) ? 16 : alpha_reg;
            if (span < 2) span = 2;
            n = (len_reg > MAX_LEN) ? MAX_LEN : len_reg;
            if (n < 1) n = 1;
            top = SYM_W'(span - 1);
            beat.symbols = '0;
            beat.found   = 1'b0;

            if (restart_req) restart_listing();

            while (!exhausted && !beat.found) begin
                if (at_start) begin
                    sym[0]   = '0;
                    cur_len  = 1;
                    at_start = 1'b0;
                end else begin
                    sym[cur_len-1] = sym[cur_len-1] + SYM_W'(1);
                end
                if (cur_len == n) begin
                    for (int i = 0; i < n; i++) beat.symbols[SYM_W*i +: SYM_W] = sym[i];
                    beat.found = 1'b1;
                end
                // periodic extension up to full length
                period = cur_len;
                while (cur_len < n) begin
                    sym[cur_len] = sym[cur_len - period];
                    cur_len++;
                end
                // drop trailing maximal symbols
                while (cur_len > 0 && sym[cur_len-1] == top) cur_len--;
                if (cur_len == 0) exhausted = 1'b1;
            end
            pending_words.insert(pending_words.size(), beat);
        endfunction

        function void flag(string what, logic [WORD_W-1:0] expv, logic [WORD_W-1:0] actv);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, expv, actv);
        endfunction

        function void check_word(logic [WORD_W-1:0] got_symbols, logic got_found);
            t_word_beat want;
            if (pending_words.size() == 0) begin
                flag("unexpected word", '0, got_symbols);
                return;
            end
            want = pending_words.pop_front();
            if (got_symbols !== want.symbols) flag("word_symbols", want.symbols, got_symbols);
            if (got_found !== want.found) flag("found", want.found, got_found);
        endfunction
    endclass

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    i_restart   = 1'b0;
    logic                    i_out_stall = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = CFG_ALPHABET;
    logic [CFG_DATA_W-1:0]   i_cfg_data  = '0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic [WORD_W-1:0]       o_word_symbols;
    logic                    o_found;

    lyndon_listing listing = new();

    lyndon_word_generator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_restart      (i_restart),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_word_symbols (o_word_symbols),
        .o_found        (o_found),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver stall: regimes of no stall, light, heavy and long stall runs
    int unsigned regime      = 0;
    int unsigned regime_left = 0;
    int unsigned stall_run   = 0;

    always @(posedge i_clk) begin
        if (regime_left == 0) begin
            regime      = $urandom_range(0, 3);
            regime_left = $urandom_range(50, 300);
        end else begin
            regime_left--;
        end
        case (regime)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 9) < 7);
            default: begin
                if (stall_run > 0) begin
                    stall_run--;
                    i_out_stall <= 1'b1;
                end else if ($urandom_range(0, 15) == 0) begin
                    stall_run = $urandom_range(5, 30);
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        endcase
    end

    // Result beats
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            listing.check_word(o_word_symbols, o_found);
    end

    task automatic wait_drained();
        while (listing.pending() != 0) @(posedge i_clk);
    endtask

    // Register writes; only called with the block idle
    task automatic write_regs(input logic [CFG_DATA_W-1:0] alpha,
                              input logic [CFG_DATA_W-1:0] len,
                              input bit do_alpha, input bit do_len);
        if (do_alpha) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_ALPHABET;
            i_cfg_data  <= alpha;
            @(posedge i_clk);
            listing.write_reg(CFG_ALPHABET, alpha);
        end
        if (do_len) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_LENGTH;
            i_cfg_data  <= len;
            @(posedge i_clk);
            listing.write_reg(CFG_LENGTH, len);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Request beats in bursts with gaps; ends with valid low and all words back
    task automatic run_requests(input bit plan[$]);
        int unsigned burst_left;
        int unsigned gap;
        bit          pause_all;
        burst_left = 0;
        for (int k = 0; k < plan.size(); k++) begin
            if (burst_left == 0) begin
                gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 4);
                pause_all  = ($urandom_range(0, 79) == 0);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(1, 8);
                if (k != 0 && (gap != 0 || pause_all)) i_in_valid <= 1'b0;
                if (pause_all) wait_drained();
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_restart  <= plan[k];
            do @(posedge i_clk); while (o_in_stall);
            listing.take_request(plan[k]);
            burst_left--;
        end
        i_in_valid <= 1'b0;
        wait_drained();
    endtask

    logic [CFG_DATA_W-1:0] alpha_picks [6] = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31};
    logic [CFG_DATA_W-1:0] len_picks   [6] = '{5'd0, 5'd1, 5'd12, 5'd13, 5'd15, 5'd16};

    initial begin
        bit                    plan[$];
        logic [CFG_DATA_W-1:0] alpha;
        logic [CFG_DATA_W-1:0] len;
        int unsigned           random_sent;
        int unsigned           n_items;
        int unsigned           pick;

        listing.reset_regs();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: first words, then a restart
        plan = {1'b0, 1'b0, 1'b0};
        run_requests(plan);
        plan = {1'b1};
        run_requests(plan);

        // Rewriting an unchanged register restarts the listing
        write_regs(5'd2, 5'd0, 1'b1, 1'b0);
        plan = {1'b0};
        run_requests(plan);

        // Both registers below range: binary, length one, runs dry
        write_regs(5'd0, 5'd0, 1'b1, 1'b1);
        plan = {1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
        run_requests(plan);

        // Both above range: saturate to 16 symbols, 12 long
        write_regs(5'd31, 5'd31, 1'b1, 1'b1);
        plan = {1'b0, 1'b0, 1'b0};
        run_requests(plan);

        // Alphabet below range, length two; single word then exhausted
        write_regs(5'd1, 5'd2, 1'b1, 1'b1);
        plan = {1'b0, 1'b0};
        run_requests(plan);

        write_regs(5'd16, 5'd12, 1'b1, 1'b1);
        plan = {1'b0, 1'b0, 1'b1};
        run_requests(plan);

        // Random phases, each under its own settings
        random_sent = 0;
        while (random_sent < 1350) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // small alphabets and lengths: listing may run to its end
                alpha   = CFG_DATA_W'($urandom_range(2, 4));
                len     = CFG_DATA_W'($urandom_range(1, 6));
                n_items = $urandom_range(3, 40);
                write_regs(alpha, len, 1'b1, 1'b1);
            end else if (pick < 70) begin
                alpha   = CFG_DATA_W'($urandom_range(0, 31));
                len     = CFG_DATA_W'($urandom_range(0, 31));
                n_items = $urandom_range(10, 60);
                write_regs(alpha, len, 1'b1, 1'b1);
            end else if (pick < 85) begin
                alpha   = alpha_picks[$urandom_range(0, 5)];
                len     = len_picks[$urandom_range(0, 5)];
                n_items = $urandom_range(5, 40);
                write_regs(alpha, len, 1'b1, 1'b1);
            end else begin
                alpha   = CFG_DATA_W'($urandom_range(0, 31));
                len     = CFG_DATA_W'($urandom_range(0, 31));
                n_items = $urandom_range(5, 40);
                if ($urandom_range(0, 1) == 0) write_regs(alpha, len, 1'b1, 1'b0);
                else write_regs(alpha, len, 1'b0, 1'b1);
            end
            plan.delete();
            repeat (n_items) plan.insert(plan.size(), ($urandom_range(0, 19) == 0));
            run_requests(plan);
            random_sent += n_items;
        end

        repeat (40) @(posedge i_clk);
        if (listing.mismatches == 0 && listing.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #24_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
